// ===== hw/rtl/blc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package blc_pkg;

  localparam int LEVELS       = 32;
  localparam int POWER_STATES = 4;
  localparam int TOP_LEVEL    = (LEVELS - 1 > 31) ? 31 : LEVELS - 1;
  localparam int TOP_STATE    = (POWER_STATES - 1 > 3) ? 3 : POWER_STATES - 1;

  localparam int KIND_W   = 3;
  localparam int LEVEL_W  = 5;
  localparam int PSTATE_W = 2;
  localparam int RAW_W    = 8;
  localparam int BRIGHT_W = 7;

  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [PSTATE_W-1:0] pstate_t;
  typedef logic [BRIGHT_W-1:0] bright_t;

  localparam level_t  TOP_LEVEL_V = level_t'(TOP_LEVEL);
  localparam pstate_t TOP_STATE_V = pstate_t'(TOP_STATE);

  typedef enum logic [KIND_W-1:0] {
    KIND_SYNC  = 3'd0,
    KIND_UP    = 3'd1,
    KIND_DOWN  = 3'd2,
    KIND_SET   = 3'd3,
    KIND_QUERY = 3'd4
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              display_idle;
    pstate_t           target_state;
    logic              screen_on;
    logic [RAW_W-1:0]  raw_reading;
    logic              domain_powered;
    logic              raise_accepted;
  } cmd_t;

  typedef struct packed {
    logic    write_brightness;
    bright_t raw_brightness;
    logic    panel_on_cmd;
    logic    panel_off_cmd;
    logic    request_valid;
    pstate_t request_state;
    pstate_t reported_state;
    pstate_t max_state;
    level_t  level_now;
  } rsp_t;

  typedef struct packed {
    level_t  level;
    level_t  user_level;
    pstate_t power_state;
  } ctl_state_t;

  localparam bright_t RAW_TABLE [32] = '{
    7'd127, 7'd71, 7'd69, 7'd67, 7'd65, 7'd63, 7'd61, 7'd59,
    7'd58,  7'd56, 7'd54, 7'd52, 7'd50, 7'd48, 7'd46, 7'd44,
    7'd42,  7'd40, 7'd38, 7'd37, 7'd35, 7'd33, 7'd31, 7'd29,
    7'd27,  7'd25, 7'd23, 7'd21, 7'd19, 7'd18, 7'd16, 7'd14
  };

  function automatic level_t cap_of(input pstate_t s);
    level_t c;
    unique case (s)
      2'd0:    c = 5'd0;
      2'd1:    c = 5'd1;
      2'd2:    c = 5'd8;
      default: c = 5'd31;
    endcase
    return c;
  endfunction

  function automatic bright_t raw_of(input level_t l);
    return RAW_TABLE[l];
  endfunction

  function automatic pstate_t fitting_state(input level_t l);
    pstate_t f;
    f = TOP_STATE_V;
    for (int i = TOP_STATE; i >= 0; i--) begin
      if (l <= cap_of(pstate_t'(i))) begin
        f = pstate_t'(i);
      end
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/backlight_level_power_controller.sv =====
// Backlight level and power-state controller.
// Requests enter on cmd_valid/cmd_ready/cmd: a sync, a brightness up or down
// press, a power-state change or a domain query. Each request yields exactly
// one response on rsp_valid/rsp_ready/rsp, in request order: a panel
// brightness write, panel on/off commands, a power-state request, a query
// report and the level after the request.
// A request taken into the request register moves on to the response register
// once the output is free. Throughput: one request per cycle while rsp_ready holds;
// the table search and the update logic sit in one stage between the request
// register and the response register, and the level, user level and power state
// update there. When the receiver stalls, the response holds and the request
// register keeps taking one more request; cmd_ready drops only once both stages
// are full. Reset clears both valid flags and sets level, user level and power
// state to zero (panel off, lowest state).
`timescale 1ns / 1ps
`default_nettype none

module backlight_level_power_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire blc_pkg::cmd_t  cmd,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output blc_pkg::rsp_t       rsp
);

  logic                hold_valid;
  blc_pkg::cmd_t       hold;
  blc_pkg::ctl_state_t state;
  blc_pkg::ctl_state_t state_next;
  blc_pkg::rsp_t       rsp_next;
  logic                advance;

  assign advance   = hold_valid && (!rsp_valid || rsp_ready);
  assign cmd_ready = !hold_valid || advance;

  blc_step u_step (
    .cmd      (hold),
    .cur      (state),
    .nxt      (state_next),
    .rsp_next (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      state      <= '0;
    end else begin
      if (cmd_ready) begin
        hold_valid <= cmd_valid;
      end
      if (advance) begin
        state     <= state_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      hold <= cmd;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && rsp_valid && !rsp_ready) |-> !cmd_ready)
    else $error("request taken while both stages are full");

  a_on_writes: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.panel_on_cmd) |-> rsp.write_brightness)
    else $error("panel switched on without a brightness write");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.write_brightness) |-> (rsp.raw_brightness == '0))
    else $error("raw brightness set without a write");

  a_off_level: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.panel_off_cmd) |-> (rsp.level_now == '0 && !rsp.request_valid))
    else $error("panel off with a nonzero level or a state request");

endmodule

`default_nettype wire

// ===== hw/rtl/blc_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blc_search (
  input  wire logic [blc_pkg::RAW_W-1:0] raw_reading,
  output blc_pkg::level_t                found
);

  always_comb begin
    found = blc_pkg::TOP_LEVEL_V;
    for (int i = blc_pkg::TOP_LEVEL; i >= 0; i--) begin
      if (raw_reading >= {1'b0, blc_pkg::raw_of(blc_pkg::level_t'(i))}) begin
        found = blc_pkg::level_t'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/blc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blc_step (
  input  wire blc_pkg::cmd_t       cmd,
  input  wire blc_pkg::ctl_state_t cur,
  output blc_pkg::ctl_state_t      nxt,
  output blc_pkg::rsp_t            rsp_next
);

  blc_pkg::level_t  found;
  blc_pkg::pstate_t ps;
  blc_pkg::level_t  raise_cap;
  blc_pkg::level_t  raise_level;
  blc_pkg::pstate_t raise_fit;
  blc_pkg::level_t  down_level;
  blc_pkg::level_t  target_cap;
  logic             wr;
  logic             on_cmd;
  logic             off_cmd;
  logic             req;
  blc_pkg::pstate_t req_st;
  blc_pkg::pstate_t rep;
  blc_pkg::pstate_t maxs;

  blc_search u_search (
    .raw_reading (cmd.raw_reading),
    .found       (found)
  );

  assign ps          = (cur.power_state > blc_pkg::TOP_STATE_V) ? blc_pkg::TOP_STATE_V
                                                                : cur.power_state;
  assign target_cap  = blc_pkg::cap_of(cmd.target_state);
  assign raise_cap   = target_cap;
  assign raise_level = (cur.user_level < raise_cap) ? cur.user_level : raise_cap;
  assign raise_fit   = blc_pkg::fitting_state(raise_level);
  assign down_level  = blc_pkg::level_t'(cur.level - 1'b1);

  always_comb begin
    nxt     = cur;
    wr      = 1'b0;
    on_cmd  = 1'b0;
    off_cmd = 1'b0;
    req     = 1'b0;
    req_st  = '0;
    rep     = '0;
    maxs    = '0;
    unique case (blc_pkg::kind_t'(cmd.kind))
      blc_pkg::KIND_SYNC: begin
        if (cmd.screen_on) begin
          nxt.level      = found;
          nxt.user_level = found;
        end else begin
          nxt.level      = '0;
          nxt.user_level = '0;
        end
      end
      blc_pkg::KIND_UP: begin
        if (!cmd.display_idle) begin
          if (cur.level < blc_pkg::cap_of(ps)) begin
            nxt.level      = blc_pkg::level_t'(cur.level + 1'b1);
            nxt.user_level = blc_pkg::level_t'(cur.level + 1'b1);
            wr             = 1'b1;
          end else if (ps < blc_pkg::TOP_STATE_V) begin
            req    = 1'b1;
            req_st = blc_pkg::pstate_t'(ps + 1'b1);
            if (cmd.raise_accepted && cur.user_level < blc_pkg::TOP_LEVEL_V) begin
              nxt.user_level = blc_pkg::level_t'(cur.user_level + 1'b1);
            end
          end
        end
      end
      blc_pkg::KIND_DOWN: begin
        if (!cmd.display_idle && ps != '0 && cur.level != '0) begin
          nxt.level      = down_level;
          nxt.user_level = down_level;
          wr             = 1'b1;
          if (down_level <= blc_pkg::cap_of(blc_pkg::pstate_t'(ps - 1'b1))) begin
            req    = 1'b1;
            req_st = blc_pkg::pstate_t'(ps - 1'b1);
          end
        end
      end
      blc_pkg::KIND_SET: begin
        if (cmd.target_state <= blc_pkg::TOP_STATE_V) begin
          if (cmd.target_state > ps) begin
            on_cmd    = (ps == '0);
            nxt.level = raise_level;
            wr        = 1'b1;
            if (ps > raise_fit) begin
              req    = 1'b1;
              req_st = raise_fit;
            end
          end else if (cmd.target_state < ps) begin
            if (cmd.target_state == '0) begin
              off_cmd   = 1'b1;
              nxt.level = '0;
            end else if (cur.level > target_cap) begin
              nxt.level = target_cap;
              wr        = 1'b1;
            end
          end
          nxt.power_state = cmd.target_state;
        end
      end
      blc_pkg::KIND_QUERY: begin
        if (cmd.domain_powered) begin
          rep  = blc_pkg::fitting_state(cur.level);
          maxs = blc_pkg::TOP_STATE_V;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_next.write_brightness = wr;
    rsp_next.raw_brightness   = wr ? blc_pkg::raw_of(nxt.level) : '0;
    rsp_next.panel_on_cmd     = on_cmd;
    rsp_next.panel_off_cmd    = off_cmd;
    rsp_next.request_valid    = req;
    rsp_next.request_state    = req_st;
    rsp_next.reported_state   = rep;
    rsp_next.max_state        = maxs;
    rsp_next.level_now        = nxt.level;
  end

endmodule

`default_nettype wire
